### rtl/sliding_window_min_max_top_assert.svh
// assertion macros for the sliding window min/max block
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH

// checked only while out of reset
`define SWMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SWMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/swmm_pkg.sv
// shared constants and types of the sliding window min/max block
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int WS_W            = 7;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic shift;
    logic launch;
    logic adv;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/swmm_cell.sv
// one cell of the window chain: a stored sample and a running min/max pair
`timescale 1ns / 1ps
`default_nettype none

module swmm_cell
  import swmm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  input  logic signed [SAMPLE_BITS-1:0] lo_i,
  input  logic signed [SAMPLE_BITS-1:0] hi_i,
  output logic signed [SAMPLE_BITS-1:0] lo_o,
  output logic signed [SAMPLE_BITS-1:0] hi_o
);

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] lo_q, lo_d;
  logic signed [SAMPLE_BITS-1:0] hi_q, hi_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sample_q <= sample_i;
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    priority if (start_i && ctrl_i.launch) begin
      // the oldest sample of the window seeds the pair
      lo_d = sample_q;
      hi_d = sample_q;
    end else if (ctrl_i.adv) begin
      lo_d = (sample_q < lo_i) ? sample_q : lo_i;
      hi_d = (sample_q > hi_i) ? sample_q : hi_i;
    end else begin
      lo_d = lo_q;
      hi_d = hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign sample_o = sample_q;
  assign lo_o     = lo_q;
  assign hi_o     = hi_q;

endmodule

`default_nettype wire

### rtl/swmm_ctrl.sv
// sequencer, stream counters, window register and output register
`timescale 1ns / 1ps
`default_nettype none

module swmm_ctrl
  import swmm_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int SEEN_W     = $clog2(MAX_WINDOW + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  input  logic                          cfg_we_i,
  input  logic [WS_W-1:0]               cfg_wdata_i,
  output cell_ctrl_t                    cell_ctrl_o,
  output logic [IDX_W-1:0]              tap_idx_o,
  input  logic signed [SAMPLE_BITS-1:0] head_lo_i,
  input  logic signed [SAMPLE_BITS-1:0] head_hi_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_lo_o,
  output logic signed [SAMPLE_BITS-1:0] out_hi_o
);

  localparam int CW = (WS_W > SEEN_W) ? WS_W : SEEN_W;

  logic [SEEN_W-1:0] seen_q, seen_d, seen_inc;
  logic [SEEN_W-1:0] wlen_q, wlen_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              launch_q, launch_d;
  logic              oval_q, oval_d;
  logic signed [SAMPLE_BITS-1:0] olo_q, ohi_q;
  logic [CW-1:0]     ws_ext;
  logic              acc, want, cap, adv;

  // clamp the written window length into 1..MAX_WINDOW
  always_comb begin
    ws_ext = CW'(cfg_wdata_i);
    wlen_d = wlen_q;
    if (cfg_we_i) begin
      priority if (ws_ext == '0) begin
        wlen_d = SEEN_W'(1);
      end else if (ws_ext > CW'(MAX_WINDOW)) begin
        wlen_d = SEEN_W'(MAX_WINDOW);
      end else begin
        wlen_d = SEEN_W'(ws_ext);
      end
    end
  end

  assign tap_idx_o = IDX_W'(wlen_q - SEEN_W'(1));

  assign seen_inc = (seen_q < SEEN_W'(MAX_WINDOW)) ? seen_q + SEEN_W'(1) : seen_q;
  assign want     = (seen_inc >= wlen_q);

  // the pair walks from the oldest cell down to cell zero
  assign adv = busy_q && !launch_q && (cnt_q != '0);
  assign cap = busy_q && !launch_q && (cnt_q == '0) && (!oval_q || out_ready_i);

  assign in_ready_o = !busy_q || cap;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    seen_d   = seen_q;
    busy_d   = busy_q;
    launch_d = 1'b0;
    cnt_d    = cnt_q;
    oval_d   = oval_q;
    if (acc) begin
      seen_d   = in_last_i ? '0 : seen_inc;
      busy_d   = want;
      launch_d = want;
    end else if (cap) begin
      busy_d = 1'b0;
    end
    if (launch_q) begin
      cnt_d = tap_idx_o;
    end else if (adv) begin
      cnt_d = cnt_q - IDX_W'(1);
    end
    if (cap) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      wlen_q   <= SEEN_W'(1);
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      cnt_q    <= '0;
      oval_q   <= 1'b0;
    end else begin
      seen_q   <= seen_d;
      wlen_q   <= wlen_d;
      busy_q   <= busy_d;
      launch_q <= launch_d;
      cnt_q    <= cnt_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      olo_q <= head_lo_i;
      ohi_q <= head_hi_i;
    end
  end

  assign cell_ctrl_o.shift  = acc;
  assign cell_ctrl_o.launch = launch_q;
  assign cell_ctrl_o.adv    = adv;

  assign out_valid_o = oval_q;
  assign out_lo_o    = olo_q;
  assign out_hi_o    = ohi_q;

endmodule

`default_nettype wire

### rtl/sliding_window_min_max_top.sv
// Sliding window min/max: each accepted sample shifts into a chain of MAX_WINDOW
// cells; once window_size samples of the current stream are in, one result carries
// the minimum and maximum of the last window_size samples. A sample that completes a
// window occupies the block until its result is captured (a launch step, then the
// min/max pair steps one cell per cycle from the oldest sample down to the newest);
// a sample that completes no window does not occupy it. The result sits in an output
// register, and the next sample is taken in the same cycle the result moves there.
// tlast ends a stream; the next sample starts a new window. window_size 0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_min_max_top
  import swmm_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // sample
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // window_min, window_max
  input  logic             cfg_we_i,
  input  logic [WS_W-1:0]  cfg_wdata_i
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  cell_ctrl_t       cell_ctrl;
  logic [IDX_W-1:0] tap_idx;
  logic signed [SAMPLE_BITS-1:0] smp [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] lo  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] hi  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] out_lo, out_hi;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] smp_in, lo_in, hi_in;
    logic                          start;

    if (k == 0) begin : g_head
      assign smp_in = s_axis_tdata[SAMPLE_BITS-1:0];
    end else begin : g_body
      assign smp_in = smp[k-1];
    end

    if (k == MAX_WINDOW - 1) begin : g_tail
      assign lo_in = '0;
      assign hi_in = '0;
    end else begin : g_link
      assign lo_in = lo[k+1];
      assign hi_in = hi[k+1];
    end

    assign start = (tap_idx == IDX_W'(k));

    swmm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .start_i (start),
      .sample_i(smp_in),
      .sample_o(smp[k]),
      .lo_i    (lo_in),
      .hi_i    (hi_in),
      .lo_o    (lo[k]),
      .hi_o    (hi[k])
    );
  end

  swmm_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cell_ctrl_o(cell_ctrl),
    .tap_idx_o  (tap_idx),
    .head_lo_i  (lo[0]),
    .head_hi_i  (hi[0]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_lo_o   (out_lo),
    .out_hi_o   (out_hi)
  );

  assign m_axis_tdata = OUT_W'({out_hi, out_lo});

endmodule

`default_nettype wire

### rtl/swmm_checker.sv
// port-level checks of the sliding window min/max block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_min_max_top_assert.svh"

module swmm_checker
  import swmm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OUT_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             cfg_we_i
);

  logic                          stalled;
  logic signed [SAMPLE_BITS-1:0] min_s, max_s;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign min_s   = m_axis_tdata[SAMPLE_BITS-1:0];
  assign max_s   = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // a stalled result keeps its data
  `SWMM_ASSERT(a_out_hold, stalled |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // minimum never above maximum
  `SWMM_ASSERT(a_min_le_max, m_axis_tvalid |-> min_s <= max_s, "window minimum above maximum")

  // window size only changes while the block is idle
  `SWMM_ASSERT(a_cfg_idle, cfg_we_i |-> s_axis_tready && !m_axis_tvalid, "config written while busy")

  // no result shows while reset is applied
  `SWMM_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind sliding_window_min_max_top swmm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swmm_checker (.*);

`default_nettype wire
